[hw/rtl/b64u_pkg.sv]
// ----------------------------------------------------------------------------
// b64u_pkg
// Shared types, constants and the alphabet lookup for the base64url encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64u_pkg;

  // Character queue sizing: room for two items' worth of characters
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // Six-bit digit mask
  localparam logic [5:0] SIX_BIT_MASK = 6'h3F;

  // Position within a three-byte group, one-hot
  typedef enum logic [2:0] {
    PH_0 = 3'b001,
    PH_1 = 3'b010,
    PH_2 = 3'b100
  } phase_t;

  // One output character and its end marker
  typedef struct packed {
    logic [6:0] char_code;
    logic       end_of_text;
  } char_t;

  // Characters produced by one byte, handed to the queue
  typedef struct packed {
    logic  push;   // at least one character
    logic  two;    // second character present
    char_t c0;
    char_t c1;
  } push_t;

  // Alphabet: A-Z, a-z, 0-9, '-', '_'
  function automatic logic [6:0] b64u_char(input logic [5:0] digit);
    logic [7:0] code;
    code = 8'd0;
    if (digit < 6'd26) begin
      code = 8'd65 + {2'b00, digit};
    end else if (digit < 6'd52) begin
      code = 8'd71 + {2'b00, digit};          // 'a' - 26
    end else if (digit < 6'd62) begin
      code = {2'b00, digit} - 8'd4;           // '0' - 52
    end else if (digit == 6'd62) begin
      code = 8'd45;                           // '-'
    end else begin
      code = 8'd95;                           // '_'
    end
    return code[6:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/b64u_if.sv]
// ----------------------------------------------------------------------------
// b64u_in_if / b64u_out_if
// Valid/ready channels for raw bytes in and base64url characters out.
// ----------------------------------------------------------------------------
`default_nettype none

interface b64u_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64u_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

`default_nettype wire

[hw/rtl/b64u_char_fifo.sv]
// ----------------------------------------------------------------------------
// b64u_char_fifo
// Small character queue: takes one or two characters per cycle, gives one.
// ----------------------------------------------------------------------------
`default_nettype none

module b64u_char_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire b64u_pkg::push_t  push_in,
  output logic                  room_two,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output b64u_pkg::char_t       out_char
);

  b64u_pkg::char_t                   mem_r [b64u_pkg::FIFO_DEPTH];
  logic [b64u_pkg::FIFO_AW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [b64u_pkg::FIFO_AW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [b64u_pkg::FIFO_CW-1:0]      count_r, count_nxt;
  logic [b64u_pkg::FIFO_AW-1:0]      wr_ptr_p1;
  logic [b64u_pkg::FIFO_CW-1:0]      n_push;
  logic                              pop;

  // Flags
  assign out_valid = (count_r != '0);
  assign room_two  = (count_r <= b64u_pkg::FIFO_CW'(b64u_pkg::FIFO_DEPTH - 2));
  assign out_char  = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign wr_ptr_p1 = wr_ptr_r + b64u_pkg::FIFO_AW'(1);

  // Pointer and count update
  always_comb begin
    n_push = '0;
    if (push_in.push) begin
      n_push = push_in.two ? b64u_pkg::FIFO_CW'(2) : b64u_pkg::FIFO_CW'(1);
    end
    wr_ptr_nxt = wr_ptr_r + n_push[b64u_pkg::FIFO_AW-1:0];
    rd_ptr_nxt = rd_ptr_r + {{(b64u_pkg::FIFO_AW-1){1'b0}}, pop};
    count_nxt  = count_r + n_push - {{(b64u_pkg::FIFO_CW-1){1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push_in.push) begin
      mem_r[wr_ptr_r] <= push_in.c0;
      if (push_in.two) begin
        mem_r[wr_ptr_p1] <= push_in.c1;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/base64url_stream_encoder.sv]
// Queueing: an accepted byte's characters are queued behind any still waiting.
// Throughput: one byte per cycle while the output is taken every cycle and
//   bytes give one character each; a byte giving two characters is drained
//   one character at a time through the single-character result port.
// Reset: synchronous, active low; group phase and leftover bits clear, queue empties.
// ----------------------------------------------------------------------------
// base64url_stream_encoder
// Unpadded base64url encoder: one byte per input item, characters out.
// ----------------------------------------------------------------------------
`default_nettype none

module base64url_stream_encoder (
  input  wire logic   clk,
  input  wire logic   rst_n,
  b64u_in_if.sink     in_bus,
  b64u_out_if.source  out_bus
);

  b64u_pkg::phase_t  phase_r, phase_nxt;
  logic [3:0]        left_r, left_nxt;
  logic              room_two;
  logic              accept;
  logic [5:0]        dig0, dig1;
  logic              two;
  logic              last1;
  b64u_pkg::push_t   push;
  b64u_pkg::char_t   head;
  logic [7:0]        b;
  logic              fin;

  assign in_bus.ready = room_two;
  assign accept       = in_bus.valid && room_two;
  assign b            = in_bus.data_byte;
  assign fin          = in_bus.final_byte;

  // Split the byte into six-bit digits for the current group phase
  always_comb begin
    dig0      = b[7:2];
    dig1      = {b[1:0], 4'b0000};
    two       = fin;
    last1     = fin;
    phase_nxt = fin ? b64u_pkg::PH_0 : b64u_pkg::PH_1;
    left_nxt  = fin ? 4'd0 : {2'b00, b[1:0]};
    unique case (phase_r)
      b64u_pkg::PH_1: begin
        dig0      = {left_r[1:0], b[7:4]};
        dig1      = {b[3:0], 2'b00};
        phase_nxt = fin ? b64u_pkg::PH_0 : b64u_pkg::PH_2;
        left_nxt  = fin ? 4'd0 : b[3:0];
      end
      b64u_pkg::PH_2: begin
        dig0      = {left_r, b[7:6]};
        dig1      = b[5:0] & b64u_pkg::SIX_BIT_MASK;
        two       = 1'b1;
        phase_nxt = b64u_pkg::PH_0;
        left_nxt  = 4'd0;
      end
      default: begin
        // phase 0, also any stray code
      end
    endcase
  end

  // Characters for the queue
  always_comb begin
    push.push           = accept;
    push.two            = two;
    push.c0.char_code   = b64u_pkg::b64u_char(dig0);
    push.c0.end_of_text = 1'b0;
    push.c1.char_code   = b64u_pkg::b64u_char(dig1);
    push.c1.end_of_text = last1;
  end

  // Group state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= b64u_pkg::PH_0;
      left_r  <= 4'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
    end
  end

  b64u_char_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_in   (push),
    .room_two  (room_two),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .out_char  (head)
  );

  assign out_bus.char_code   = head.char_code;
  assign out_bus.end_of_text = head.end_of_text;

endmodule

`default_nettype wire

[hw/rtl/b64u_checker.sv]
// ----------------------------------------------------------------------------
// b64u_checker
// Port-level checks for the base64url encoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module b64u_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [6:0] char_code,
  input wire logic       end_of_text
);

  // Queue is empty straight after reset
  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // An accepted byte always leaves a character ready next cycle
  a_char_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("no character after accepted byte");

  // Only alphabet characters appear
  a_alphabet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((char_code >= 7'd65 && char_code <= 7'd90) ||
                   (char_code >= 7'd97 && char_code <= 7'd122) ||
                   (char_code >= 7'd48 && char_code <= 7'd57) ||
                   char_code == 7'd45 || char_code == 7'd95))
    else $error("character outside base64url alphabet");

  // A stalled character holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(char_code) && $stable(end_of_text)))
    else $error("stalled character changed");

endmodule

bind base64url_stream_encoder b64u_checker u_b64u_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_bus.valid),
  .in_ready    (in_bus.ready),
  .out_valid   (out_bus.valid),
  .out_ready   (out_bus.ready),
  .char_code   (out_bus.char_code),
  .end_of_text (out_bus.end_of_text)
);

`default_nettype wire
